// ----- rtl/core/ssfp_pkg.sv -----
// ssfp_pkg: types, constants and helper functions shared by the status frame parser
// used by ssfp_frame_check, ssfp_rsp_skid and servo_status_frame_parser
// no dependencies

package ssfp_pkg;

   // frame layout
   localparam logic [7:0] HDR_BYTE        = 8'hFF;
   localparam int         FB_PAYLOAD      = 15;
   localparam int         PAYLOAD_IDX_W   = $clog2(FB_PAYLOAD);
   localparam logic [7:0] PAYLOAD_START   = 8'd5;
   localparam logic [7:0] LEN_FIELD_EXTRA = 8'd2;
   localparam logic [7:0] BYTE_INDEX_MAX  = 8'd255;

   // byte positions before the payload
   localparam logic [7:0] POS_ID  = 8'd2;
   localparam logic [7:0] POS_LEN = 8'd3;
   localparam logic [7:0] POS_ERR = 8'd4;

   // sign bit positions of the sign-magnitude words
   localparam logic [3:0] WORD_SIGN_BIT = 4'd15;
   localparam logic [3:0] LOAD_SIGN_BIT = 4'd10;

   // payload offsets of the decoded fields
   localparam int OFS_POSITION    = 0;
   localparam int OFS_SPEED       = 2;
   localparam int OFS_LOAD        = 4;
   localparam int OFS_VOLTAGE     = 6;
   localparam int OFS_TEMPERATURE = 7;
   localparam int OFS_MOVING      = 10;
   localparam int OFS_CURRENT     = 13;

   // status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER   = 3'd1;
   localparam logic [2:0] ST_BAD_LENGTH   = 3'd2;
   localparam logic [2:0] ST_BAD_ID       = 3'd3;
   localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
   localparam logic [2:0] ST_SERVO_ERROR  = 3'd5;

   // configuration register indexes
   localparam int         CSR_INDEX_W     = 1;
   localparam logic [0:0] REG_EXPECTED_ID = 1'd0;
   localparam logic [0:0] REG_REPLY_KIND  = 1'd1;
   localparam logic [7:0] EXPECTED_ID_RST = 8'd1;
   localparam logic       REPLY_KIND_RST  = 1'b1;

   // response channel width, fields packed from bit 0 and padded to bytes
   localparam int RSP_FIELDS_W = 92;
   localparam int RSP_DATA_W   = 96;

   // one result item
   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         servo_error_bits;
      logic signed [15:0] position;
      logic signed [15:0] speed;
      logic signed [15:0] load;
      logic [7:0]         voltage;
      logic [7:0]         temperature;
      logic               moving;
      logic signed [15:0] current;
   } rsp_type;

   // sign-magnitude word: if the sign bit is set, clear it and negate the rest, 16-bit wrap
   function automatic logic [15:0] sign_mag(input logic [15:0] raw,
                                            input logic [3:0]  sign_pos);
      logic [15:0] mask;
      logic [15:0] mag;
      mask = 16'd1 << sign_pos;
      mag  = raw & ~mask;
      if ((raw & mask) != 16'd0) begin
         return 16'(~mag + 16'd1);
      end
      return raw;
   endfunction

endpackage

// ----- rtl/core/servo_status_frame_parser.sv -----
// servo_status_frame_parser: top level of the servo status reply parser
// depends on ssfp_pkg, ssfp_frame_check and ssfp_rsp_skid
//
// Usage
//   req_*  : one received reply byte per transfer, req_tlast on the final byte.
//   rsp_*  : one result per reply, issued for the transfer that carries req_tlast.
//   csr_*  : register writes, index 0 expected_id, index 1 reply_kind; always
//            ready, to be written only while no reply is in progress.
//   Each byte updates the byte counter, the running sum, the fault flags and
//   the 15-byte payload store; the final byte also forms the status and decoded
//   fields, which are registered in the output register, or in the skid entry
//   while the output holds a result. Throughput: one byte per cycle while
//   req_tready is high.
//   Stall: the output register plus a one-entry skid buffer let bytes keep
//   flowing while a result waits; req_tready drops only when both hold a result.
//   Reset (synchronous, active high): counters, flags and both output entries
//   clear, expected_id returns to 1 and reply_kind to feedback; the payload
//   store is not cleared.

module servo_status_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   // fields from bit 0: rx_byte[7:0]
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fields from bit 0: status[2:0], servo_error_bits[10:3], position[26:11],
   // speed[42:27], load[58:43], voltage[66:59], temperature[74:67],
   // moving[75], current[91:76], zero pad[95:92]
   output logic [ssfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_data
);

   logic [7:0]        expected_id_ff;
   logic              reply_kind_ff;
   logic              req_xfer;
   logic              res_valid;
   ssfp_pkg::rsp_type res;
   ssfp_pkg::rsp_type rsp_res;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= ssfp_pkg::EXPECTED_ID_RST;
         reply_kind_ff  <= ssfp_pkg::REPLY_KIND_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ssfp_pkg::REG_EXPECTED_ID: expected_id_ff <= csr_data;
            ssfp_pkg::REG_REPLY_KIND:  reply_kind_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_xfer = req_tvalid && req_tready;

   // per-byte checks and final decode
   ssfp_frame_check u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_xfer),
      .rx_byte     (req_tdata),
      .last_byte   (req_tlast),
      .expected_id (expected_id_ff),
      .reply_kind  (reply_kind_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   // output register and skid entry
   ssfp_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (rsp_res)
   );

   // pack the result, first field lowest
   assign rsp_tdata = {{(ssfp_pkg::RSP_DATA_W - ssfp_pkg::RSP_FIELDS_W){1'b0}},
                       rsp_res.current,
                       rsp_res.moving,
                       rsp_res.temperature,
                       rsp_res.voltage,
                       rsp_res.load,
                       rsp_res.speed,
                       rsp_res.position,
                       rsp_res.servo_error_bits,
                       rsp_res.status};

endmodule

// ----- rtl/core/ssfp_frame_check.sv -----
// ssfp_frame_check: per-byte frame state, payload store and the final status decode
// depends on ssfp_pkg

module ssfp_frame_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        rx_byte,
   input  logic              last_byte,
   input  logic [7:0]        expected_id,
   input  logic              reply_kind,
   output logic              res_valid,
   output ssfp_pkg::rsp_type res
);

   logic [7:0] byte_index_ff, byte_index_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic       header_fault_ff, header_fault_in;
   logic       id_fault_ff, id_fault_in;
   logic       length_fault_ff, length_fault_in;
   logic       checksum_match_ff, checksum_match_in;
   logic [7:0] error_byte_ff, error_byte_in;
   logic [7:0] payload_ff [ssfp_pkg::FB_PAYLOAD];

   logic [7:0]                       plen;
   logic                             payload_wr;
   logic [ssfp_pkg::PAYLOAD_IDX_W-1:0] payload_idx;
   logic [7:0]                       payload_ofs;
   logic                             too_short;
   logic [2:0]                       status;

   assign plen = reply_kind ? 8'(ssfp_pkg::FB_PAYLOAD) : 8'd0;
   assign payload_ofs = byte_index_ff - ssfp_pkg::PAYLOAD_START;
   assign payload_idx = payload_ofs[ssfp_pkg::PAYLOAD_IDX_W-1:0];

   // per-byte update of the frame checks
   always_comb begin
      header_fault_in   = header_fault_ff;
      id_fault_in       = id_fault_ff;
      length_fault_in   = length_fault_ff;
      checksum_match_in = checksum_match_ff;
      error_byte_in     = error_byte_ff;
      running_sum_in    = running_sum_ff;
      payload_wr        = 1'b0;
      if (byte_index_ff < ssfp_pkg::POS_ID) begin
         if (rx_byte != ssfp_pkg::HDR_BYTE) begin
            header_fault_in = 1'b1;
         end
      end else if (byte_index_ff == ssfp_pkg::POS_ID) begin
         id_fault_in    = (rx_byte != expected_id);
         running_sum_in = running_sum_ff + rx_byte;
      end else if (byte_index_ff == ssfp_pkg::POS_LEN) begin
         length_fault_in = (rx_byte != plen + ssfp_pkg::LEN_FIELD_EXTRA);
         running_sum_in  = running_sum_ff + rx_byte;
      end else if (byte_index_ff == ssfp_pkg::POS_ERR) begin
         error_byte_in  = rx_byte;
         running_sum_in = running_sum_ff + rx_byte;
      end else if (byte_index_ff < ssfp_pkg::PAYLOAD_START + plen) begin
         payload_wr     = 1'b1;
         running_sum_in = running_sum_ff + rx_byte;
      end else if (byte_index_ff == ssfp_pkg::PAYLOAD_START + plen) begin
         checksum_match_in = (~running_sum_ff == rx_byte);
      end
      byte_index_in = (byte_index_ff == ssfp_pkg::BYTE_INDEX_MAX) ?
                      byte_index_ff : byte_index_ff + 8'd1;
   end

   // frame state, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset || (byte_valid && last_byte)) begin
         byte_index_ff     <= '0;
         running_sum_ff    <= '0;
         header_fault_ff   <= 1'b0;
         id_fault_ff       <= 1'b0;
         length_fault_ff   <= 1'b0;
         checksum_match_ff <= 1'b0;
         error_byte_ff     <= '0;
      end else if (byte_valid) begin
         byte_index_ff     <= byte_index_in;
         running_sum_ff    <= running_sum_in;
         header_fault_ff   <= header_fault_in;
         id_fault_ff       <= id_fault_in;
         length_fault_ff   <= length_fault_in;
         checksum_match_ff <= checksum_match_in;
         error_byte_ff     <= error_byte_in;
      end
   end

   // payload store, no reset
   always_ff @(posedge clock) begin
      if (byte_valid && payload_wr) begin
         payload_ff[payload_idx] <= rx_byte;
      end
   end

   // status in check order, with this byte folded in
   assign too_short = (byte_index_ff < ssfp_pkg::PAYLOAD_START + plen);

   always_comb begin
      if (too_short) begin
         status = ssfp_pkg::ST_BAD_LENGTH;
      end else if (header_fault_in) begin
         status = ssfp_pkg::ST_BAD_HEADER;
      end else if (id_fault_in) begin
         status = ssfp_pkg::ST_BAD_ID;
      end else if (length_fault_in) begin
         status = ssfp_pkg::ST_BAD_LENGTH;
      end else if (!checksum_match_in) begin
         status = ssfp_pkg::ST_BAD_CHECKSUM;
      end else if (error_byte_in != 8'd0) begin
         status = ssfp_pkg::ST_SERVO_ERROR;
      end else begin
         status = ssfp_pkg::ST_OK;
      end
   end

   // result fields
   always_comb begin
      res = '0;
      res.status = status;
      if (status == ssfp_pkg::ST_OK || status == ssfp_pkg::ST_SERVO_ERROR) begin
         res.servo_error_bits = error_byte_in;
      end
      if (status == ssfp_pkg::ST_OK && reply_kind) begin
         res.position = ssfp_pkg::sign_mag({payload_ff[ssfp_pkg::OFS_POSITION + 1],
                                            payload_ff[ssfp_pkg::OFS_POSITION]},
                                           ssfp_pkg::WORD_SIGN_BIT);
         res.speed = ssfp_pkg::sign_mag({payload_ff[ssfp_pkg::OFS_SPEED + 1],
                                         payload_ff[ssfp_pkg::OFS_SPEED]},
                                        ssfp_pkg::WORD_SIGN_BIT);
         res.load = ssfp_pkg::sign_mag({payload_ff[ssfp_pkg::OFS_LOAD + 1],
                                        payload_ff[ssfp_pkg::OFS_LOAD]},
                                       ssfp_pkg::LOAD_SIGN_BIT);
         res.voltage     = payload_ff[ssfp_pkg::OFS_VOLTAGE];
         res.temperature = payload_ff[ssfp_pkg::OFS_TEMPERATURE];
         res.moving      = (payload_ff[ssfp_pkg::OFS_MOVING] != 8'd0);
         res.current = ssfp_pkg::sign_mag({payload_ff[ssfp_pkg::OFS_CURRENT + 1],
                                           payload_ff[ssfp_pkg::OFS_CURRENT]},
                                          ssfp_pkg::WORD_SIGN_BIT);
      end
   end

   assign res_valid = byte_valid && last_byte;

endmodule

// ----- rtl/core/ssfp_rsp_skid.sv -----
// ssfp_rsp_skid: result output register with one skid entry behind it
// depends on ssfp_pkg

module ssfp_rsp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ssfp_pkg::rsp_type in_res,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ssfp_pkg::rsp_type out_res
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   ssfp_pkg::rsp_type out_res_ff, out_res_in;
   ssfp_pkg::rsp_type skid_res_ff, skid_res_in;
   logic              out_free;

   assign out_free = !out_valid_ff || out_ready;
   assign in_ready = !skid_valid_ff;

   // next state of output and skid entries
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_res_in    = out_res_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_res_in    = skid_res_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_res_in   = in_res;
            out_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_res_in   = in_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a waiting skid entry moves to the output when it drains
   a_skid_refill: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff.status <= ssfp_pkg::ST_SERVO_ERROR))
      else $error("undefined status code");

   // error byte only reported once the checksum passed
   a_err_bits_gated: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.status != ssfp_pkg::ST_OK &&
       out_res_ff.status != ssfp_pkg::ST_SERVO_ERROR)
      |-> (out_res_ff.servo_error_bits == 8'd0))
      else $error("servo error bits on a failed frame");

endmodule
